@@ rtl/kru_pkg.sv @@
// Shared types and constants for the keyed record upsert table.
// Used by kru_cell and keyed_record_upsert_table_top; depends on nothing.
package kru_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W    = 48;
    localparam int ITEM_W   = 48;
    localparam int PLAYER_W = 16;
    localparam int FLAGS_W  = 8;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 3;
    localparam int FILL_W   = 7;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_UPSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_UPDATED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_HIT      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_MISS     = 3'd4;
    localparam logic [STAT_W-1:0] STAT_CLEARED  = 3'd5;

    // Search token that travels down the row of cells, one cell per cycle.
    // On a lookup hit the data fields are replaced by the stored record.
    typedef struct packed {
        logic                vld;
        logic [REQ_W-1:0]    op;
        logic [KEY_W-1:0]    key;
        logic [ITEM_W-1:0]   item;
        logic [PLAYER_W-1:0] player;
        logic [FLAGS_W-1:0]  flags;
        logic                found;
        logic                inserted;
    } kru_tok_t;

endpackage

@@ rtl/kru_cell.sv @@
// One table cell: holds a single record and passes the search token on.
// Depends on kru_pkg.
module kru_cell
    import kru_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic [CNT_W-1:0] used_count,
    input  kru_tok_t         tok_in,
    output kru_tok_t         tok_out
);

    logic [KEY_W-1:0]    key_reg;
    logic [ITEM_W-1:0]   item_reg;
    logic [PLAYER_W-1:0] player_reg;
    logic [FLAGS_W-1:0]  flags_reg;
    kru_tok_t            tok_reg;
    kru_tok_t            tok_next;

    logic [CNT_W-1:0] idx_ext;
    logic             searching;
    logic             match;
    logic             append;

    assign idx_ext   = CNT_W'(cell_idx);
    assign searching = tok_in.vld && !tok_in.found;
    assign match     = searching && (idx_ext < used_count) && (key_reg == tok_in.key)
                       && ((tok_in.op == REQ_UPSERT) || (tok_in.op == REQ_LOOKUP));
    // The first unfilled cell takes an upsert that matched nowhere before it.
    assign append    = searching && (tok_in.op == REQ_UPSERT) && (idx_ext == used_count);

    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            tok_next.found = 1'b1;
            if (tok_in.op == REQ_LOOKUP)
            begin
                tok_next.item   = item_reg;
                tok_next.player = player_reg;
                tok_next.flags  = flags_reg;
            end
        end
        else if (append)
        begin
            tok_next.found    = 1'b1;
            tok_next.inserted = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (append)
        begin
            key_reg <= tok_in.key;
        end
        if (append || (match && (tok_in.op == REQ_UPSERT)))
        begin
            item_reg   <= tok_in.item;
            player_reg <= tok_in.player;
            flags_reg  <= tok_in.flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ rtl/keyed_record_upsert_table_top.sv @@
// Keyed record table with upsert, lookup and clear, built as a row of cells.
// Depends on kru_pkg and kru_cell.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_ready    | req_type, key, item_value, player_num, flag_bits
//  out     | out_valid / out_ready  | status, out_item, out_player, out_flags, fill_count
//
// A request walks the row of TABLE_DEPTH cells, one cell per cycle; its result is
// registered as the token leaves the last cell. One request is in the row at a
// time. in_ready is low during a walk and while a result waits to be taken.
// Reset empties the table; record contents need no clearing.
module keyed_record_upsert_table_top
    import kru_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [KEY_W-1:0]    key,
    input  logic [ITEM_W-1:0]   item_value,
    input  logic [PLAYER_W-1:0] player_num,
    input  logic [FLAGS_W-1:0]  flag_bits,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STAT_W-1:0]   status,
    output logic [ITEM_W-1:0]   out_item,
    output logic [PLAYER_W-1:0] out_player,
    output logic [FLAGS_W-1:0]  out_flags,
    output logic [FILL_W-1:0]   fill_count
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [STAT_W-1:0]   status_reg;
    logic [ITEM_W-1:0]   item_reg;
    logic [PLAYER_W-1:0] player_reg;
    logic [FLAGS_W-1:0]  flags_reg;
    logic [FILL_W-1:0]   fill_reg;

    logic [STAT_W-1:0]   status_next;
    logic [ITEM_W-1:0]   item_next;
    logic [PLAYER_W-1:0] player_next;
    logic [FLAGS_W-1:0]  flags_next;

    kru_tok_t tok [TABLE_DEPTH+1];
    kru_tok_t tail;
    logic     in_fire;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        tok[0].vld      = in_fire;
        tok[0].op       = req_type;
        tok[0].key      = key;
        tok[0].item     = item_value;
        tok[0].player   = player_num;
        tok[0].flags    = flag_bits;
        tok[0].found    = 1'b0;
        tok[0].inserted = 1'b0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        kru_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(g)),
            .used_count (count_reg),
            .tok_in     (tok[g]),
            .tok_out    (tok[g+1])
        );
    end

    assign tail = tok[TABLE_DEPTH];

    // Result formation when the token leaves the last cell.
    always_comb
    begin
        status_next = STAT_MISS;
        item_next   = '0;
        player_next = '0;
        flags_next  = '0;
        count_next  = count_reg;
        unique case (tail.op)
            REQ_UPSERT:
            begin
                if (tail.inserted)
                begin
                    status_next = STAT_INSERTED;
                    count_next  = count_reg + CNT_W'(1);
                end
                else if (tail.found)
                begin
                    status_next = STAT_UPDATED;
                end
                else
                begin
                    status_next = STAT_DROPPED;
                end
            end
            REQ_LOOKUP:
            begin
                if (tail.found)
                begin
                    status_next = STAT_HIT;
                    item_next   = tail.item;
                    player_next = tail.player;
                    flags_next  = tail.flags;
                end
            end
            REQ_CLEAR:
            begin
                status_next = STAT_CLEARED;
                count_next  = '0;
            end
            default:
            begin
                status_next = STAT_MISS;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (tail.vld)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (tail.vld)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.vld)
        begin
            status_reg <= status_next;
            item_reg   <= item_next;
            player_reg <= player_next;
            flags_reg  <= flags_next;
            fill_reg   <= FILL_W'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_item   = item_reg;
    assign out_player = player_reg;
    assign out_flags  = flags_reg;
    assign fill_count = fill_reg;

endmodule
